// ===== hw/rtl/cau_pkg.sv =====
// Shared constants, operation codes and control struct for the complex arithmetic unit.
package cau_pkg;

	localparam int CAU_DATA_WIDTH = 32;
	localparam int CAU_FRAC_BITS  = 16;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Per-word control that rides along the pipeline; lane 0 is real, lane 1 imaginary.
	typedef struct packed {
		logic       is_div;
		logic       dz;
		logic [1:0] neg;
		logic [1:0] sat;
	} cau_ctl_t;

endpackage

// ===== hw/rtl/cau_front.sv =====
// Front end: operand register, partial products, numerators, divisor norm and magnitudes.
module cau_front import cau_pkg::*; #(
	parameter int DATA_WIDTH = CAU_DATA_WIDTH,
	parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 rdy,
	input  logic [1:0]                           op,
	input  logic signed [DATA_WIDTH-1:0]         a_re,
	input  logic signed [DATA_WIDTH-1:0]         a_im,
	input  logic signed [DATA_WIDTH-1:0]         b_re,
	input  logic signed [DATA_WIDTH-1:0]         b_im,
	input  logic                                 rdy_in,
	output logic                                 out_valid,
	output cau_ctl_t                             ctl,
	output logic [2*DATA_WIDTH-1:0]              den,
	output logic [1:0][2*DATA_WIDTH:0]           rem,
	output logic [1:0][DATA_WIDTH:0]             nlo,
	output logic [1:0][DATA_WIDTH:0]             quo
);

	localparam int W  = DATA_WIDTH;
	localparam int DW = 2 * W;
	localparam int RW = DW + 1;
	localparam int QW = W + 1;
	localparam int NW = DW + FRAC_BITS;

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	logic [1:0]            op_s1, op_s2;
	logic signed [W-1:0]   ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [DW-1:0]  prr_s2, pii_s2, pri_s2, pir_s2, srr_s2, sii_s2;
	logic signed [W:0]     sre_s2, sim_s2;

	logic signed [W:0]     sre_d, sim_d;
	logic [DW-1:0]         den_d;
	logic signed [DW:0]    val [2];
	logic [1:0][DW:0]      mag, shv;
	logic [1:0][NW-1:0]    nn;
	logic [1:0][RW-1:0]    rem_d;
	logic [1:0][QW-1:0]    nlo_d, quo_d;
	cau_ctl_t              ctl_d;

	assign adv3 = !v_s3 || rdy_in;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign rdy  = adv1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1 <= op;
			ar_s1 <= a_re;
			ai_s1 <= a_im;
			br_s1 <= b_re;
			bi_s1 <= b_im;
		end
	end

	// Sum or difference at one extra bit, exact
	always_comb begin
		if (op_s1 == OP_SUB) begin
			sre_d = {ar_s1[W-1], ar_s1} - {br_s1[W-1], br_s1};
			sim_d = {ai_s1[W-1], ai_s1} - {bi_s1[W-1], bi_s1};
		end else begin
			sre_d = {ar_s1[W-1], ar_s1} + {br_s1[W-1], br_s1};
			sim_d = {ai_s1[W-1], ai_s1} + {bi_s1[W-1], bi_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			op_s2  <= op_s1;
			prr_s2 <= ar_s1 * br_s1;
			pii_s2 <= ai_s1 * bi_s1;
			pri_s2 <= ar_s1 * bi_s1;
			pir_s2 <= ai_s1 * br_s1;
			srr_s2 <= br_s1 * br_s1;
			sii_s2 <= bi_s1 * bi_s1;
			sre_s2 <= sre_d;
			sim_s2 <= sim_d;
		end
	end

	assign den_d = DW'(srr_s2) + DW'(sii_s2);

	always_comb begin
		case (op_s2)
			OP_MUL: begin
				val[0] = {prr_s2[DW-1], prr_s2} - {pii_s2[DW-1], pii_s2};
				val[1] = {pri_s2[DW-1], pri_s2} + {pir_s2[DW-1], pir_s2};
			end
			OP_DIV: begin
				val[0] = {prr_s2[DW-1], prr_s2} + {pii_s2[DW-1], pii_s2};
				val[1] = {pir_s2[DW-1], pir_s2} - {pri_s2[DW-1], pri_s2};
			end
			default: begin
				val[0] = (DW+1)'(sre_s2);
				val[1] = (DW+1)'(sim_s2);
			end
		endcase
	end

	always_comb begin
		ctl_d.is_div = (op_s2 == OP_DIV);
		ctl_d.dz     = (op_s2 == OP_DIV) && (den_d == '0);
		for (int l = 0; l < 2; l++) begin
			ctl_d.neg[l] = val[l][DW];
			mag[l]       = val[l][DW] ? (DW+1)'(-val[l]) : (DW+1)'(val[l]);
			shv[l]       = (op_s2 == OP_MUL) ? (mag[l] >> FRAC_BITS) : mag[l];
			// Dividend scaled up by the fraction bits; top part seeds the remainder
			nn[l]        = NW'(mag[l][DW-1:0]) << FRAC_BITS;
			rem_d[l]     = RW'(nn[l][NW-1:QW]);
			nlo_d[l]     = nn[l][QW-1:0];
			if (op_s2 == OP_DIV) begin
				quo_d[l]     = '0;
				ctl_d.sat[l] = (rem_d[l] >= RW'(den_d));
			end else begin
				quo_d[l]     = shv[l][QW-1:0];
				ctl_d.sat[l] = |shv[l][DW:QW];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			ctl <= ctl_d;
			den <= den_d;
			rem <= rem_d;
			nlo <= nlo_d;
			quo <= quo_d;
		end
	end

endmodule

// ===== hw/rtl/cau_cell.sv =====
// One restoring-division cell: shift in a dividend bit, compare and subtract, emit a quotient bit.
module cau_cell import cau_pkg::*; #(
	parameter int DATA_WIDTH = CAU_DATA_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        rdy,
	input  cau_ctl_t                    ctl_in,
	input  logic [2*DATA_WIDTH-1:0]     den_in,
	input  logic [1:0][2*DATA_WIDTH:0]  rem_in,
	input  logic [1:0][DATA_WIDTH:0]    nlo_in,
	input  logic [1:0][DATA_WIDTH:0]    quo_in,
	input  logic                        rdy_in,
	output logic                        out_valid,
	output cau_ctl_t                    ctl,
	output logic [2*DATA_WIDTH-1:0]     den,
	output logic [1:0][2*DATA_WIDTH:0]  rem,
	output logic [1:0][DATA_WIDTH:0]    nlo,
	output logic [1:0][DATA_WIDTH:0]    quo
);

	localparam int RW = 2 * DATA_WIDTH + 1;
	localparam int QW = DATA_WIDTH + 1;

	logic               v_q, adv;
	logic [1:0][RW-1:0] r, rem_d;
	logic [1:0][QW-1:0] nlo_d, quo_d;
	logic [1:0]         ge;

	assign adv       = !v_q || rdy_in;
	assign rdy       = adv;
	assign out_valid = v_q;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			r[l]  = {rem_in[l][RW-2:0], nlo_in[l][QW-1]};
			ge[l] = (r[l] >= RW'(den_in));
			if (ctl_in.is_div) begin
				rem_d[l] = ge[l] ? (r[l] - RW'(den_in)) : r[l];
				nlo_d[l] = nlo_in[l] << 1;
				quo_d[l] = {quo_in[l][QW-2:0], ge[l]};
			end else begin
				rem_d[l] = rem_in[l];
				nlo_d[l] = nlo_in[l];
				quo_d[l] = quo_in[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl <= ctl_in;
			den <= den_in;
			rem <= rem_d;
			nlo <= nlo_d;
			quo <= quo_d;
		end
	end

endmodule

// ===== hw/rtl/cau_back.sv =====
// Back end: saturate, apply sign, zero-divisor override and output register.
module cau_back import cau_pkg::*; #(
	parameter int DATA_WIDTH = CAU_DATA_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       rdy,
	input  cau_ctl_t                   ctl_in,
	input  logic [1:0][DATA_WIDTH:0]   quo_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [DATA_WIDTH-1:0]      res_re,
	output logic [DATA_WIDTH-1:0]      res_im,
	output logic                       div_zero,
	output logic                       overflow
);

	localparam int W  = DATA_WIDTH;
	localparam int QW = W + 1;
	localparam logic [QW-1:0] LIM = QW'(1) << (W - 1);

	logic                v_q, adv;
	logic [1:0][QW-1:0]  top, mag;
	logic [1:0]          ovf;
	logic [1:0][W-1:0]   res;

	assign adv       = !v_q || out_ready;
	assign rdy       = adv;
	assign out_valid = v_q;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			top[l] = ctl_in.neg[l] ? LIM : (LIM - QW'(1));
			ovf[l] = ctl_in.sat[l] || (quo_in[l] > top[l]);
			mag[l] = ovf[l] ? top[l] : quo_in[l];
			res[l] = ctl_in.neg[l] ? W'(-mag[l]) : mag[l][W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctl_in.dz) begin
				res_re   <= '0;
				res_im   <= '0;
				div_zero <= 1'b1;
				overflow <= 1'b0;
			end else begin
				res_re   <= res[0];
				res_im   <= res[1];
				div_zero <= 1'b0;
				overflow <= |ovf;
			end
		end
	end

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front end, division cell chain and output stage.
// Complex add, subtract, multiply and divide on signed fixed-point operands (DATA_WIDTH bits,
// FRAC_BITS fraction bits). One word is accepted per cycle while s_tready is high, and one result word
// comes out per word, in order. Every operation passes through the same stages:
// three front-end stages (operand register, partial products, numerator and divisor norm),
// DATA_WIDTH + 1 division cells that each resolve one quotient bit, and the output register.
// Add, subtract and multiply ride through the cells untouched so results never reorder.
// Multiply truncates the exact product toward zero; divide returns the conjugate product over
// |b|^2, truncated toward zero. Saturated parts set overflow; a zero divisor returns 0 + 0i
// with div_zero set and overflow clear. Each stage holds while the one after it is full and
// stalled, so bubbles fill while a result waits on m_tready.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = CAU_DATA_WIDTH,
	parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata from bit 0 up: a_re, a_im, b_re, b_im, zero padding to whole bytes
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
	// tuser: op
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata from bit 0 up: res_re, res_im, zero padding to whole bytes
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]   m_tdata,
	// tuser from bit 0 up: div_zero, overflow
	output logic [1:0]                          m_tuser
);

	localparam int W     = DATA_WIDTH;
	localparam int DW    = 2 * W;
	localparam int QW    = W + 1;
	localparam int OUT_W = ((2*DATA_WIDTH+7)/8)*8;

	// Stage k of the chain is the input of cell k; stage QW feeds the output register
	logic     [QW:0]                c_v;
	logic     [QW:0]                c_rdy;
	cau_ctl_t                       c_ctl [QW+1];
	logic     [QW:0][DW-1:0]        c_den;
	logic     [QW:0][1:0][DW:0]     c_rem;
	logic     [QW:0][1:0][QW-1:0]   c_nlo;
	logic     [QW:0][1:0][QW-1:0]   c_quo;

	logic [W-1:0] res_re, res_im;
	logic         div_zero, overflow;

	cau_front #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.rdy       (s_tready),
		.op        (s_tuser),
		.a_re      (s_tdata[W-1:0]),
		.a_im      (s_tdata[2*W-1:W]),
		.b_re      (s_tdata[3*W-1:2*W]),
		.b_im      (s_tdata[4*W-1:3*W]),
		.rdy_in    (c_rdy[0]),
		.out_valid (c_v[0]),
		.ctl       (c_ctl[0]),
		.den       (c_den[0]),
		.rem       (c_rem[0]),
		.nlo       (c_nlo[0]),
		.quo       (c_quo[0])
	);

	// One quotient bit per cell, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_cell
		cau_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_v[k]),
			.rdy       (c_rdy[k]),
			.ctl_in    (c_ctl[k]),
			.den_in    (c_den[k]),
			.rem_in    (c_rem[k]),
			.nlo_in    (c_nlo[k]),
			.quo_in    (c_quo[k]),
			.rdy_in    (c_rdy[k+1]),
			.out_valid (c_v[k+1]),
			.ctl       (c_ctl[k+1]),
			.den       (c_den[k+1]),
			.rem       (c_rem[k+1]),
			.nlo       (c_nlo[k+1]),
			.quo       (c_quo[k+1])
		);
	end

	cau_back #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_v[QW]),
		.rdy       (c_rdy[QW]),
		.ctl_in    (c_ctl[QW]),
		.quo_in    (c_quo[QW]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_re    (res_re),
		.res_im    (res_im),
		.div_zero  (div_zero),
		.overflow  (overflow)
	);

	assign m_tdata = OUT_W'({res_im, res_re});
	assign m_tuser = {overflow, div_zero};

`ifndef NO_ASSERTIONS
	// A zero divisor returns exactly zero and never reports overflow
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (!m_tuser[1] && res_re == '0 && res_im == '0))
		else $error("div_zero word carries nonzero data or overflow");

	// With the output register empty the whole chain can advance
	a_rdy_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register is empty");

	// Without overflow, a zero-divisor word carries a zero real part
	a_sat_re: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> !m_tuser[0] || (res_re == '0))
		else $error("real part nonzero on zero divisor");
`endif

endmodule
